/* rtl/olb_pkg.sv */
// Shared types, constants and helpers for the overdub loop buffer.
// Used by olb_front, olb_cmd_fifo, olb_back and overdub_loop_buffer; depends on nothing.
package olb_pkg;

  // Loop memory geometry and sample format.
  localparam int unsigned MaxLoopSamples = 524288;
  localparam int unsigned SampleWidth    = 16;
  localparam int unsigned AddrW          = $clog2(MaxLoopSamples);

  // Port field widths.
  localparam int unsigned AudioW = 16;
  localparam int unsigned LenW   = 20;

  // The clamped length can hold MaxLoopSamples itself.
  localparam int unsigned EffLenW = AddrW + 1;
  localparam int unsigned CmpW    = (LenW > EffLenW) ? LenW : EffLenW;
  localparam int unsigned BeatW   = EffLenW - 4;
  localparam int unsigned BarW    = EffLenW - 2;

  // Length register reset value.
  localparam logic [LenW-1:0] LenReset = LenW'(352800);

  // Click levels: 0.15 rounded to the sample grid, and exactly 0.5.
  localparam longint ClickBeat = (15 * (longint'(1) << (SampleWidth - 1)) + 50) / 100;
  localparam longint ClickBar  = longint'(1) << (SampleWidth - 2);

  // Configuration port.
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic [PaddrW-3:0] RegLoopLength = '0;

  // Command queue between front and back.
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned PtrW     = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CntW     = $clog2(CmdDepth + 1);

  typedef enum logic [1:0] {
    OP_PASS,
    OP_PLAY,
    OP_CLEAR
  } op_e;

  // One classified request as handed from front to back.
  typedef struct packed {
    op_e                      op;
    logic signed [AudioW-1:0] audio;
    logic                     rec;
    logic [AddrW-1:0]         addr;
    logic                     beat_hit;
    logic                     bar_hit;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_RESOLVE,
    ST_SWEEP
  } back_state_e;

  // Signed add that clips to the sample range.
  function automatic logic signed [SampleWidth-1:0] sat_add(
    input logic signed [SampleWidth-1:0] a,
    input logic signed [SampleWidth-1:0] b
  );
    logic signed [SampleWidth:0] s;
    s = (SampleWidth + 1)'(a) + (SampleWidth + 1)'(b);
    if (s[SampleWidth] != s[SampleWidth-1]) begin
      sat_add = s[SampleWidth] ? {1'b1, {(SampleWidth - 1){1'b0}}}
                               : {1'b0, {(SampleWidth - 1){1'b1}}};
    end else begin
      sat_add = s[SampleWidth-1:0];
    end
  endfunction

endpackage

/* rtl/overdub_loop_buffer.sv */
// Overdub loop buffer, top level: ties the front end, the command queue and the
// memory back end together. Depends on olb_pkg, olb_front, olb_cmd_fifo, olb_back.
//
// Audio looper over a 524288 x 16 sample memory. A sample request passes through
// the back end as dequeue, registered memory read, then the result and, for a
// played sample, the write back. The back end takes no new request until it is
// through with the last, and it waits while the output register is still full.
// A clear request zeroes the memory one address per cycle. After reset the same
// sweep runs, during which full stays high; the length register can be written
// throughout. Up to two requests queue ahead of the back end, and one finished
// result waits in the output register.
module overdub_loop_buffer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [olb_pkg::PaddrW-1:0]        paddr,
  input  logic [olb_pkg::PdataW-1:0]        pwdata,
  output logic [olb_pkg::PdataW-1:0]        prdata,
  output logic                              pready,
  // Request side
  input  logic                              push,
  output logic                              full,
  input  logic                              func_i,
  input  logic signed [olb_pkg::AudioW-1:0] audio_in_i,
  input  logic                              play_on_i,
  input  logic                              record_on_i,
  // Result side
  output logic                              empty,
  input  logic                              pop,
  output logic signed [olb_pkg::AudioW-1:0] audio_out_o
);

  olb_pkg::cmd_t front_cmd;
  olb_pkg::cmd_t queue_cmd;
  logic          queue_full;
  logic          queue_valid;
  logic          queue_pop;
  logic          init_busy;
  logic          accept;

  // No request is taken while the queue is full or the power-up sweep runs.
  assign full   = queue_full || init_busy;
  assign accept = push && !full;

  olb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .accept_i    (accept),
    .func_i      (func_i),
    .audio_in_i  (audio_in_i),
    .play_on_i   (play_on_i),
    .record_on_i (record_on_i),
    .cmd_o       (front_cmd)
  );

  olb_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  olb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .init_busy_o (init_busy),
    .pop         (pop),
    .empty       (empty),
    .audio_out_o (audio_out_o)
  );

endmodule

/* rtl/olb_front.sv */
// Front end of the loop buffer: configuration register, play position tracking
// and classification of incoming requests into commands. Depends on olb_pkg.
module olb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [olb_pkg::PaddrW-1:0]    paddr,
  input  logic [olb_pkg::PdataW-1:0]    pwdata,
  output logic [olb_pkg::PdataW-1:0]    prdata,
  output logic                          pready,
  // Accepted request
  input  logic                          accept_i,
  input  logic                          func_i,
  input  logic signed [olb_pkg::AudioW-1:0] audio_in_i,
  input  logic                          play_on_i,
  input  logic                          record_on_i,
  // Classified command
  output olb_pkg::cmd_t                 cmd_o
);

  logic [olb_pkg::LenW-1:0]    len_q, len_d;
  logic [olb_pkg::AddrW-1:0]   pos_q, pos_d;
  logic [olb_pkg::BeatW-1:0]   beat_cnt_q, beat_cnt_d;
  logic [olb_pkg::BarW-1:0]    bar_cnt_q, bar_cnt_d;
  logic [olb_pkg::EffLenW-1:0] eff_len;
  logic [olb_pkg::BeatW-1:0]   beat_len;
  logic [olb_pkg::BarW-1:0]    bar_len;
  logic [olb_pkg::EffLenW-1:0] pos_inc;
  logic [olb_pkg::BeatW-1:0]   beat_inc;
  logic [olb_pkg::BarW-1:0]    bar_inc;
  logic                        reg_sel;
  logic                        cfg_we;
  logic                        advance;

  // Register decode; the port never waits.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[olb_pkg::PaddrW-1:2] == olb_pkg::RegLoopLength);
  assign cfg_we  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? olb_pkg::PdataW'(len_q) : '0;

  // Effective length is the register clamped to 1..MaxLoopSamples.
  always_comb begin
    if (len_q == '0) begin
      eff_len = olb_pkg::EffLenW'(1);
    end else if (olb_pkg::CmpW'(len_q) > olb_pkg::CmpW'(olb_pkg::MaxLoopSamples)) begin
      eff_len = olb_pkg::EffLenW'(olb_pkg::MaxLoopSamples);
    end else begin
      eff_len = olb_pkg::EffLenW'(len_q);
    end
  end

  // Beat spacing is length/16 and bar spacing length/4.
  assign beat_len = eff_len[olb_pkg::EffLenW-1:4];
  assign bar_len  = eff_len[olb_pkg::EffLenW-1:2];

  // Build the command for the incoming request.
  always_comb begin
    cmd_o.audio    = audio_in_i;
    cmd_o.rec      = record_on_i;
    cmd_o.addr     = pos_q;
    cmd_o.beat_hit = (beat_len != '0) && (beat_cnt_q == '0);
    cmd_o.bar_hit  = (bar_len != '0) && (bar_cnt_q == '0);
    if (func_i) begin
      cmd_o.op = olb_pkg::OP_CLEAR;
    end else if (play_on_i) begin
      cmd_o.op = olb_pkg::OP_PLAY;
    end else begin
      cmd_o.op = olb_pkg::OP_PASS;
    end
  end

  // Position and the beat and bar phase counters step together and wrap at the length.
  assign advance  = accept_i && !func_i && play_on_i;
  assign pos_inc  = olb_pkg::EffLenW'(pos_q) + olb_pkg::EffLenW'(1);
  assign beat_inc = beat_cnt_q + olb_pkg::BeatW'(1);
  assign bar_inc  = bar_cnt_q + olb_pkg::BarW'(1);

  always_comb begin
    len_d      = len_q;
    pos_d      = pos_q;
    beat_cnt_d = beat_cnt_q;
    bar_cnt_d  = bar_cnt_q;
    if (cfg_we) begin
      // A length write rewinds the loop.
      len_d      = pwdata[olb_pkg::LenW-1:0];
      pos_d      = '0;
      beat_cnt_d = '0;
      bar_cnt_d  = '0;
    end else if (advance) begin
      if (pos_inc >= eff_len) begin
        pos_d      = '0;
        beat_cnt_d = '0;
        bar_cnt_d  = '0;
      end else begin
        pos_d      = pos_inc[olb_pkg::AddrW-1:0];
        beat_cnt_d = (beat_inc == beat_len) ? '0 : beat_inc;
        bar_cnt_d  = (bar_inc == bar_len) ? '0 : bar_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= olb_pkg::LenReset;
      pos_q      <= '0;
      beat_cnt_q <= '0;
      bar_cnt_q  <= '0;
    end else begin
      len_q      <= len_d;
      pos_q      <= pos_d;
      beat_cnt_q <= beat_cnt_d;
      bar_cnt_q  <= bar_cnt_d;
    end
  end

  // The play position always lies inside the loop.
  a_pos_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    olb_pkg::EffLenW'(pos_q) < eff_len)
    else $error("play position outside loop length");

endmodule

/* rtl/olb_cmd_fifo.sv */
// Short command queue that decouples the front end from the memory back end.
// Depends on olb_pkg for the command type and depth.
module olb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  olb_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output olb_pkg::cmd_t cmd_o
);

  olb_pkg::cmd_t               entry_q [olb_pkg::CmdDepth];
  logic [olb_pkg::PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [olb_pkg::CntW-1:0]    cnt_q;

  assign full_o  = (cnt_q == olb_pkg::CntW'(olb_pkg::CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == olb_pkg::PtrW'(olb_pkg::CmdDepth - 1)) ? '0
                                                   : wr_ptr_q + olb_pkg::PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == olb_pkg::PtrW'(olb_pkg::CmdDepth - 1)) ? '0
                                                   : rd_ptr_q + olb_pkg::PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + olb_pkg::CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - olb_pkg::CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue read while empty");

endmodule

/* rtl/olb_back.sv */
// Back end of the loop buffer: owns the loop memory, runs the read-modify-write
// per sample, the clearing sweeps and the result register. Depends on olb_pkg.
module olb_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Command queue side
  input  logic                              cmd_valid_i,
  input  olb_pkg::cmd_t                     cmd_i,
  output logic                              cmd_pop_o,
  output logic                              init_busy_o,
  // Result side
  input  logic                              pop,
  output logic                              empty,
  output logic signed [olb_pkg::AudioW-1:0] audio_out_o
);

  olb_pkg::back_state_e state_q, state_d;
  olb_pkg::cmd_t        cur_q, cur_d;
  logic [olb_pkg::AddrW-1:0] sweep_q, sweep_d;

  logic [olb_pkg::SampleWidth-1:0] loop_mem [olb_pkg::MaxLoopSamples];
  logic signed [olb_pkg::SampleWidth-1:0] rd_q;

  logic                                   mem_we;
  logic [olb_pkg::AddrW-1:0]              mem_waddr;
  logic signed [olb_pkg::SampleWidth-1:0] mem_wdata;
  logic signed [olb_pkg::SampleWidth-1:0] new_val;
  logic signed [olb_pkg::SampleWidth-1:0] x_ext;

  logic                              out_valid_q, out_valid_d;
  logic signed [olb_pkg::AudioW-1:0] out_q;
  logic signed [olb_pkg::AudioW-1:0] out_data;
  logic                              out_load;
  logic                              out_free;
  logic                              sweep_last;

  // Loop memory: one write port, one registered read at the current command address.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      loop_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= loop_mem[cur_q.addr];
  end

  // New stored sample: clicks on beat and bar, or overdub which replaces them.
  always_comb begin
    x_ext   = olb_pkg::SampleWidth'(cur_q.audio);
    new_val = rd_q;
    if (cur_q.beat_hit) begin
      new_val = olb_pkg::sat_add(new_val, olb_pkg::SampleWidth'(olb_pkg::ClickBeat));
    end
    if (cur_q.bar_hit) begin
      new_val = olb_pkg::sat_add(new_val, olb_pkg::SampleWidth'(olb_pkg::ClickBar));
    end
    if (cur_q.rec) begin
      new_val = olb_pkg::sat_add(x_ext, rd_q);
    end
  end

  assign out_free   = !out_valid_q || pop;
  assign sweep_last = (sweep_q == olb_pkg::AddrW'(olb_pkg::MaxLoopSamples - 1));

  // Sequencer: next state, memory controls and result loading.
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    sweep_d   = sweep_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_q.addr;
    mem_wdata = new_val;
    out_load  = 1'b0;
    out_data  = '0;
    unique case (state_q)
      olb_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + olb_pkg::AddrW'(1);
        if (sweep_last) begin
          state_d = olb_pkg::ST_IDLE;
        end
      end
      olb_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          sweep_d   = '0;
          state_d   = olb_pkg::ST_READ;
        end
      end
      olb_pkg::ST_READ: begin
        state_d = (cur_q.op == olb_pkg::OP_CLEAR) ? olb_pkg::ST_SWEEP : olb_pkg::ST_RESOLVE;
      end
      olb_pkg::ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + olb_pkg::AddrW'(1);
        if (sweep_last) begin
          state_d = olb_pkg::ST_RESOLVE;
        end
      end
      olb_pkg::ST_RESOLVE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = olb_pkg::ST_IDLE;
          unique case (cur_q.op)
            olb_pkg::OP_PLAY: begin
              out_data = olb_pkg::AudioW'(rd_q);
              mem_we   = 1'b1;
            end
            olb_pkg::OP_PASS:  out_data = cur_q.audio;
            default:           out_data = '0;
          endcase
        end
      end
      default: state_d = olb_pkg::ST_IDLE;
    endcase
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_data;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olb_pkg::ST_INIT;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty       = !out_valid_q;
  assign audio_out_o = out_q;
  assign init_busy_o = (state_q == olb_pkg::ST_INIT);

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop |=> out_valid_q && $stable(out_q))
    else $error("pending result lost or changed");

  a_sweep_is_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == olb_pkg::ST_SWEEP |-> cur_q.op == olb_pkg::OP_CLEAR)
    else $error("memory sweep without a clear request");

endmodule
